[design/bqsd_pkg.sv]
// Package for the binary quadtree sequence decoder: geometry, stack entry,
// result and control types shared by all modules. No dependencies.
`timescale 1ns / 1ps
package bqsd_pkg;

    localparam int MAX_SIDE_LOG2   = 4;
    localparam int MAX_FRAMES_LOG2 = 4;
    localparam int STACK_DEPTH     = MAX_SIDE_LOG2 + MAX_FRAMES_LOG2;

    localparam logic [1:0] REG_SIDE   = 2'd0;
    localparam logic [1:0] REG_FRAMES = 2'd1;
    localparam logic [1:0] REG_LOW    = 2'd2;
    localparam logic [1:0] REG_HIGH   = 2'd3;

    typedef enum logic [1:0] {
        PH_NODE,
        PH_COLOUR,
        PH_CUT,
        PH_FLAG
    } t_phase;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BIT,
        ST_FIN,
        ST_END
    } t_state;

    typedef struct packed {
        logic [3:0] col;
        logic [3:0] row;
        logic [3:0] frame;
        logic [2:0] sl;
        logic [2:0] fl;
    } t_geom;

    typedef struct packed {
        t_geom      geom;
        logic       spatial;
        logic [1:0] idx;
        logic       eq;
        logic       eqc;
    } t_split;

    typedef struct packed {
        logic [3:0] col;
        logic [3:0] row;
        logic [3:0] frame;
        logic [2:0] size_log2;
        logic [2:0] span_log2;
        logic [7:0] pixel_value;
        logic       block_done;
        logic       is_last;
    } t_result;

    typedef struct packed {
        logic [2:0] side_log2;
        logic [2:0] frames_log2;
        logic [7:0] low_value;
        logic [7:0] high_value;
    } t_cfg;

    typedef struct packed {
        logic [3:0] level;
        logic       active;
    } t_status;

    // Geometry of child k of a split region.
    function automatic t_geom child_geom(input t_geom g, input logic spatial,
                                         input logic [1:0] k);
        t_geom      c;
        logic [2:0] nl;
        logic [3:0] h;
        c  = g;
        nl = 3'd0;
        h  = 4'd0;
        if (spatial) begin
            nl   = g.sl - 3'd1;
            h    = 4'd1 << nl;
            c.sl = nl;
            if (k[0]) c.col = g.col + h;
            if (k[1]) c.row = g.row + h;
        end else begin
            nl   = g.fl - 3'd1;
            h    = 4'd1 << nl;
            c.fl = nl;
            if (k[0]) c.frame = g.frame + h;
        end
        return c;
    endfunction

endpackage

[design/bqsd_front.sv]
// Front end: two-entry queue that takes code bytes from the input side.
// Depends on bqsd_pkg.
`timescale 1ns / 1ps
module bqsd_front
    import bqsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  logic [7:0] i_data,
    output logic       o_full,
    output logic       o_valid,
    output logic [7:0] o_data,
    input  logic       i_pop
);

    logic [7:0] r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       wr, rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr) r_wp <= !r_wp;
            if (rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

endmodule

[design/bqsd_outq.sv]
// Result queue of four entries between the decoder and the result side.
// Depends on bqsd_pkg.
`timescale 1ns / 1ps
module bqsd_outq
    import bqsd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    output logic    o_full,
    output logic    o_empty,
    output t_result o_data,
    input  logic    i_pop
);

    t_result    r_mem [4];
    logic [1:0] r_wp, r_rp;
    logic [2:0] r_cnt;
    logic       wr, rd;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_data  = r_mem[r_rp];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 2'd0;
            r_rp  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (wr) r_wp <= r_wp + 2'd1;
            if (rd) r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, wr} - {2'b0, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) r_mem[r_wp] <= i_data;
    end

endmodule

[design/bqsd_core.sv]
// Back end: bit-serial tree decoder with a split stack and a held result.
// Depends on bqsd_pkg.
`timescale 1ns / 1ps
module bqsd_core
    import bqsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_byte_valid,
    input  logic [7:0] i_byte,
    output logic       o_byte_pop,
    input  logic       i_outq_full,
    output logic       o_res_push,
    output t_result    o_res,
    output t_status    o_status
);

    t_split     r_stack [STACK_DEPTH];
    t_state     r_state, n_state;
    t_phase     r_phase, n_phase;
    logic [3:0] r_level, n_level;
    logic       r_active, n_active;
    t_geom      r_cur, n_cur;
    logic [7:0] r_byte, n_byte;
    logic [2:0] r_bitcnt, n_bitcnt;
    logic       r_more, n_more;
    logic       r_fv_uni, n_fv_uni;
    logic       r_fv_col, n_fv_col;
    t_result    r_held, n_held;
    logic       r_held_v, n_held_v;

    logic       go, cbit, unit, emit, emit_col, psh, psh_sp, end_push;
    t_geom      emit_geom, ch, init;
    t_split     top, stk_wd;
    logic       stk_we;
    logic [2:0] stk_wa, top_a;
    logic [1:0] last, nidx;
    logic       eq_n, eqc_n;
    t_state     after;

    assign top_a = r_level[2:0] - 3'd1;
    assign top   = r_stack[top_a];
    assign go    = !i_outq_full;
    assign cbit  = r_byte[7];
    assign unit  = (r_cur.sl == 3'd0) && (r_cur.fl == 3'd0);
    assign after = r_more ? ST_BIT : ST_END;

    always_comb begin
        init       = '0;
        init.sl    = (i_cfg.side_log2 > 3'(MAX_SIDE_LOG2)) ?
                     3'(MAX_SIDE_LOG2) : i_cfg.side_log2;
        init.fl    = (i_cfg.frames_log2 > 3'(MAX_FRAMES_LOG2)) ?
                     3'(MAX_FRAMES_LOG2) : i_cfg.frames_log2;
    end

    always_comb begin
        n_state  = r_state;
        n_phase  = r_phase;
        n_level  = r_level;
        n_active = r_active;
        n_cur    = r_cur;
        n_byte   = r_byte;
        n_bitcnt = r_bitcnt;
        n_more   = r_more;
        n_fv_uni = r_fv_uni;
        n_fv_col = r_fv_col;
        n_held   = r_held;
        n_held_v = r_held_v;
        o_byte_pop = 1'b0;
        emit     = 1'b0;
        emit_col = 1'b0;
        emit_geom = r_cur;
        psh      = 1'b0;
        psh_sp   = 1'b0;
        end_push = 1'b0;
        stk_we   = 1'b0;
        stk_wa   = top_a;
        stk_wd   = top;
        last     = top.spatial ? 2'd3 : 2'd1;
        nidx     = top.idx + 2'd1;
        ch       = child_geom(top.geom, top.spatial, nidx);
        if (top.idx == 2'd0) begin
            eq_n  = r_fv_uni;
            eqc_n = r_fv_uni && r_fv_col;
        end else begin
            eq_n  = top.eq && r_fv_uni && (r_fv_col == top.eqc);
            eqc_n = top.eqc;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (go && i_byte_valid) begin
                    o_byte_pop = 1'b1;
                    n_byte     = i_byte;
                    n_bitcnt   = 3'd0;
                    n_state    = ST_BIT;
                    if (!r_active) begin
                        n_cur    = init;
                        n_level  = 4'd0;
                        n_phase  = PH_NODE;
                        n_active = 1'b1;
                    end
                end
            end
            ST_BIT: begin
                if (go) begin
                    n_byte   = r_byte << 1;
                    n_bitcnt = r_bitcnt + 3'd1;
                    n_more   = (r_bitcnt != 3'd7);
                    n_state  = (r_bitcnt == 3'd7) ? ST_END : ST_BIT;
                    unique case (r_phase)
                        PH_NODE: begin
                            if (unit) begin
                                emit     = 1'b1;
                                emit_col = cbit;
                                n_fv_uni = 1'b1;
                                n_fv_col = cbit;
                                n_state  = ST_FIN;
                            end else if (cbit) begin
                                n_phase = PH_COLOUR;
                            end else if (r_cur.sl != 3'd0 && r_cur.fl != 3'd0) begin
                                n_phase = PH_CUT;
                            end else begin
                                psh    = 1'b1;
                                psh_sp = (r_cur.fl == 3'd0);
                            end
                        end
                        PH_COLOUR: begin
                            emit     = 1'b1;
                            emit_col = cbit;
                            n_fv_uni = 1'b1;
                            n_fv_col = cbit;
                            n_state  = ST_FIN;
                        end
                        PH_CUT: begin
                            psh    = 1'b1;
                            psh_sp = !cbit;
                        end
                        PH_FLAG: begin
                            if (cbit) begin
                                emit     = 1'b1;
                                emit_col = !top.eqc;
                                n_fv_uni = 1'b0;
                                n_state  = ST_FIN;
                            end else if (r_cur.sl != 3'd0 && r_cur.fl != 3'd0) begin
                                n_phase = PH_CUT;
                            end else begin
                                psh    = 1'b1;
                                psh_sp = (r_cur.fl == 3'd0);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_FIN: begin
                if (go) begin
                    if (r_level == 4'd0) begin
                        // Tree closed: the block ends and the rest of the byte is dropped.
                        n_active = 1'b0;
                        n_phase  = PH_NODE;
                        n_held.block_done = 1'b1;
                        n_state  = ST_END;
                    end else if (top.idx == last) begin
                        n_level  = r_level - 4'd1;
                        n_fv_uni = 1'b0;
                    end else begin
                        stk_we     = 1'b1;
                        stk_wd.idx = nidx;
                        stk_wd.eq  = eq_n;
                        stk_wd.eqc = eqc_n;
                        n_cur      = ch;
                        if (nidx == last && eq_n) begin
                            if (ch.sl == 3'd0 && ch.fl == 3'd0) begin
                                emit      = 1'b1;
                                emit_geom = ch;
                                emit_col  = !eqc_n;
                            end else begin
                                n_phase = PH_FLAG;
                                n_state = after;
                            end
                        end else begin
                            n_phase = PH_NODE;
                            n_state = after;
                        end
                    end
                end
            end
            ST_END: begin
                if (go) begin
                    end_push = r_held_v;
                    n_held_v = 1'b0;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase

        if (psh) begin
            stk_we         = 1'b1;
            stk_wa         = r_level[2:0];
            stk_wd.geom    = r_cur;
            stk_wd.spatial = psh_sp;
            stk_wd.idx     = 2'd0;
            stk_wd.eq      = 1'b0;
            stk_wd.eqc     = 1'b0;
            n_level        = r_level + 4'd1;
            n_cur          = child_geom(r_cur, psh_sp, 2'd0);
            n_phase        = PH_NODE;
        end

        if (emit) begin
            n_held_v             = 1'b1;
            n_held.col           = emit_geom.col;
            n_held.row           = emit_geom.row;
            n_held.frame         = emit_geom.frame;
            n_held.size_log2     = emit_geom.sl;
            n_held.span_log2     = emit_geom.fl;
            n_held.pixel_value   = emit_col ? i_cfg.low_value : i_cfg.high_value;
            n_held.block_done    = 1'b0;
            n_held.is_last       = 1'b0;
        end
    end

    // The held result goes out once it is known whether it ends the byte.
    assign o_res_push = (emit && r_held_v) || end_push;
    always_comb begin
        o_res         = r_held;
        o_res.is_last = end_push;
    end

    assign o_status.level  = r_level;
    assign o_status.active = r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_NODE;
            r_level  <= 4'd0;
            r_active <= 1'b0;
            r_held_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_phase  <= n_phase;
            r_level  <= n_level;
            r_active <= n_active;
            r_held_v <= n_held_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur    <= n_cur;
        r_byte   <= n_byte;
        r_bitcnt <= n_bitcnt;
        r_more   <= n_more;
        r_fv_uni <= n_fv_uni;
        r_fv_col <= n_fv_col;
        r_held   <= n_held;
        if (stk_we) r_stack[stk_wa] <= stk_wd;
    end

endmodule

[design/binary_quadtree_sequence_decoder.sv]
// Top level of the binary quadtree sequence decoder: configuration registers,
// byte queue, decoder core and result queue. Depends on bqsd_pkg and submodules.
//
//  Channel   Direction  Handshake             Payload
//  input     in         push / full           i_code_byte
//  result    out        empty / pop           o_col .. o_is_last
//  config    in         i_cfg_we (no wait)    i_cfg_idx, i_cfg_data
//
// A byte passes through a load step, a step per code bit used, a finish step
// per region completed by a bit plus one per closed stack level and inferred
// pixel, and a closing step; when the first bit closes the block the rest of
// the byte is dropped.
// Reset clears all control state; the split stack needs no clearing.
// The core stalls while the result queue is full; the byte queue keeps
// taking bytes until its two entries are used.
`timescale 1ns / 1ps
module binary_quadtree_sequence_decoder
    import bqsd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_code_byte,
    output logic       empty,
    input  logic       pop,
    output logic [3:0] o_col,
    output logic [3:0] o_row,
    output logic [3:0] o_frame,
    output logic [2:0] o_size_log2,
    output logic [2:0] o_span_log2,
    output logic [7:0] o_pixel_value,
    output logic       o_block_done,
    output logic       o_is_last,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data
);

    t_cfg       r_cfg;
    logic       byte_valid, byte_pop, res_push, outq_full;
    logic [7:0] byte_data;
    t_result    res_in, res_out;
    t_status    status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.side_log2   <= 3'd2;
            r_cfg.frames_log2 <= 3'd2;
            r_cfg.low_value   <= 8'd0;
            r_cfg.high_value  <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIDE:   r_cfg.side_log2   <= i_cfg_data[2:0];
                REG_FRAMES: r_cfg.frames_log2 <= i_cfg_data[2:0];
                REG_LOW:    r_cfg.low_value   <= i_cfg_data;
                REG_HIGH:   r_cfg.high_value  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    bqsd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (i_code_byte),
        .o_full  (full),
        .o_valid (byte_valid),
        .o_data  (byte_data),
        .i_pop   (byte_pop)
    );

    bqsd_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_byte_valid (byte_valid),
        .i_byte       (byte_data),
        .o_byte_pop   (byte_pop),
        .i_outq_full  (outq_full),
        .o_res_push   (res_push),
        .o_res        (res_in),
        .o_status     (status)
    );

    bqsd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (outq_full),
        .o_empty (empty),
        .o_data  (res_out),
        .i_pop   (pop)
    );

    assign o_col         = res_out.col;
    assign o_row         = res_out.row;
    assign o_frame       = res_out.frame;
    assign o_size_log2   = res_out.size_log2;
    assign o_span_log2   = res_out.span_log2;
    assign o_pixel_value = res_out.pixel_value;
    assign o_block_done  = res_out.block_done;
    assign o_is_last     = res_out.is_last;

    // A region that closes a block always ends the byte that caused it.
    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_block_done) |-> o_is_last)
        else $error("block_done result not marked last of its byte");

    // The split stack never grows past the deepest tree.
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.level <= 4'(STACK_DEPTH))
        else $error("split stack level out of range");

    // With no block open the stack is empty.
    a_idle_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !status.active |-> (status.level == 4'd0) || $past(status.active))
        else $error("stack left open after block end");

    // Nothing is queued right after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (empty && !full))
        else $error("queues not empty after reset");

endmodule

[sim/tb_binary_quadtree_sequence_decoder.sv]
// Self-checking testbench for binary_quadtree_sequence_decoder: a cycle-free
// tree decoder model predicts every region fill and a monitor checks them.
// Depends on bqsd_pkg and the decoder RTL.
`timescale 1ns / 1ps
module tb_binary_quadtree_sequence_decoder;
    import bqsd_pkg::*;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       push = 1'b0;
    logic       full;
    logic [7:0] i_code_byte = 8'd0;
    logic       empty;
    logic       pop = 1'b0;
    logic [3:0] o_col;
    logic [3:0] o_row;
    logic [3:0] o_frame;
    logic [2:0] o_size_log2;
    logic [2:0] o_span_log2;
    logic [7:0] o_pixel_value;
    logic       o_block_done;
    logic       o_is_last;
    logic       i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = 2'd0;
    logic [7:0] i_cfg_data = 8'd0;

    binary_quadtree_sequence_decoder dut (.*);

    always #5 i_clk = ~i_clk;

    // Decoder model state.
    t_cfg    cfg;
    t_split  stk [STACK_DEPTH];
    int      lvl;
    t_phase  phase;
    logic    active;
    t_geom   cur;
    int      nres;
    logic    done_now;
    t_result fills_due[$];

    int  send_gap_pct = 0;
    int  stall_pct = 0;
    int  hold_cycles = 0;
    bit  failed = 1'b0;

    function automatic t_geom child_of(t_split s, int k);
        t_geom c;
        c = s.geom;
        if (s.spatial) begin
            c.sl = s.geom.sl - 3'd1;
            if (k[0]) c.col = c.col + (4'd1 << c.sl);
            if (k[1]) c.row = c.row + (4'd1 << c.sl);
        end else begin
            c.fl = s.geom.fl - 3'd1;
            if (k[0]) c.frame = c.frame + (4'd1 << c.fl);
        end
        return c;
    endfunction

    task automatic add_fill(t_geom g, logic colour);
        t_result r;
        if (nres >= 16) return;
        r.col = g.col;
        r.row = g.row;
        r.frame = g.frame;
        r.size_log2 = g.sl;
        r.span_log2 = g.fl;
        r.pixel_value = colour ? cfg.low_value : cfg.high_value;
        r.block_done = 1'b0;
        r.is_last = 1'b0;
        fills_due.push_back(r);
        nres++;
    endtask

    task automatic open_split(logic spatial);
        if (lvl >= STACK_DEPTH) return;
        stk[lvl] = '{geom: cur, spatial: spatial, idx: 2'd0, eq: 1'b0, eqc: 1'b0};
        lvl++;
        cur = child_of(stk[lvl-1], 0);
        phase = PH_NODE;
    endtask

    task automatic begin_split();
        if (cur.sl > 0 && cur.fl > 0) phase = PH_CUT;
        else open_split(cur.fl == 0);
    endtask

    // Climb the stack after a child completes; v is its colour, -1 for a split or flag fill.
    task automatic close_child(int v);
        t_split s;
        int     last;
        forever begin
            if (lvl == 0) begin
                active = 1'b0;
                done_now = 1'b1;
                phase = PH_NODE;
                if (nres > 0) fills_due[$].block_done = 1'b1;
                return;
            end
            s = stk[lvl-1];
            last = s.spatial ? 3 : 1;
            if (s.idx == 0) begin
                s.eq = (v >= 0);
                s.eqc = (v > 0);
            end else if (!(v >= 0 && s.eq && v == s.eqc)) begin
                s.eq = 1'b0;
            end
            if (s.idx >= last) begin
                stk[lvl-1] = s;
                lvl--;
                v = -1;
                continue;
            end
            s.idx++;
            stk[lvl-1] = s;
            cur = child_of(s, s.idx);
            if (s.idx == last && s.eq) begin
                if (cur.sl == 0 && cur.fl == 0) begin
                    // A lone last pixel is implied: opposite colour of its siblings.
                    add_fill(cur, ~s.eqc);
                    continue;
                end
                phase = PH_FLAG;
                return;
            end
            phase = PH_NODE;
            return;
        end
    endtask

    task automatic decode_bit(logic b);
        case (phase)
            PH_NODE: begin
                if (cur.sl == 0 && cur.fl == 0) begin
                    add_fill(cur, b);
                    close_child(int'(b));
                end else if (b) phase = PH_COLOUR;
                else begin_split();
            end
            PH_COLOUR: begin
                add_fill(cur, b);
                close_child(int'(b));
            end
            PH_CUT: open_split(b == 1'b0);
            default: begin
                if (b) begin
                    add_fill(cur, (lvl > 0) ? ~stk[lvl-1].eqc : 1'b1);
                    close_child(-1);
                end else begin
                    begin_split();
                end
            end
        endcase
    endtask

    task automatic decode_byte(logic [7:0] code);
        nres = 0;
        done_now = 1'b0;
        if (!active) begin
            cur = '0;
            cur.sl = (cfg.side_log2 > MAX_SIDE_LOG2) ? 3'(MAX_SIDE_LOG2) : cfg.side_log2;
            cur.fl = (cfg.frames_log2 > MAX_FRAMES_LOG2) ? 3'(MAX_FRAMES_LOG2)
                                                         : cfg.frames_log2;
            lvl = 0;
            phase = PH_NODE;
            active = 1'b1;
        end
        for (int i = 7; i >= 0 && !done_now; i--) decode_bit(code[i]);
        if (nres > 0) fills_due[$].is_last = 1'b1;
    endtask

    // Offer one byte after an optional random gap; predict at the transfer.
    task automatic send_byte(logic [7:0] code);
        while ($urandom_range(99) < send_gap_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push <= 1'b1;
        i_code_byte <= code;
        do @(posedge i_clk); while (full);
        decode_byte(code);
    endtask

    task automatic wait_idle();
        push <= 1'b0;
        wait (fills_due.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [7:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_SIDE:   cfg.side_log2 = value[2:0];
            REG_FRAMES: cfg.frames_log2 = value[2:0];
            REG_LOW:    cfg.low_value = value;
            default:    cfg.high_value = value;
        endcase
    endtask

    task automatic set_geometry(logic [7:0] side, logic [7:0] frames);
        wait_idle();
        write_reg(REG_SIDE, side);
        write_reg(REG_FRAMES, frames);
    endtask

    // Half random bytes, the rest ones- or zero-heavy so blocks close often and trees go deep.
    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(99);
        if (sel < 50) return 8'($urandom);
        if (sel < 75) return 8'($urandom) | 8'($urandom);
        if (sel < 90) return 8'($urandom) & 8'($urandom);
        return sel[0] ? 8'hFF : 8'h00;
    endfunction

    task automatic test_directed();
        logic [7:0] codes [$];
        send_gap_pct = 0;
        stall_pct = 0;
        // Default 4x4x4 block: uniform root, then splits down to lone pixels.
        codes = '{8'h80, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h55, 8'hAA, 8'hFF, 8'hFF};
        foreach (codes[i]) send_byte(codes[i]);
        set_geometry(8'd0, 8'd0);
        write_reg(REG_LOW, 8'h00);
        write_reg(REG_HIGH, 8'hFF);
        foreach (codes[i]) send_byte(codes[i]);
        // Register values above the maximum saturate.
        set_geometry(8'd7, 8'd7);
        write_reg(REG_LOW, 8'h5A);
        write_reg(REG_HIGH, 8'hA5);
        send_byte(8'hC0);
        send_byte(8'h80);
        // Spatial only and temporal only splits, with implied and flagged last siblings.
        set_geometry(8'd1, 8'd0);
        send_byte(8'h00);
        send_byte(8'h2F);
        set_geometry(8'd0, 8'd2);
        send_byte(8'h05);
        send_byte(8'h0B);
        send_byte(8'h00);
        send_byte(8'hFF);
    endtask

    task automatic test_random(int count, int gap, int stall);
        send_gap_pct = gap;
        stall_pct = stall;
        for (int n = 0; n < count; n++) begin
            if (n % 24 == 0) begin
                wait_idle();
                // Small geometries keep most blocks short; the largest appears now and then.
                write_reg(REG_SIDE, ($urandom_range(9) == 0) ? 8'd4 : 8'($urandom_range(2)));
                write_reg(REG_FRAMES, ($urandom_range(9) == 0) ? 8'd4
                                                               : 8'($urandom_range(2)));
                write_reg(REG_LOW, 8'($urandom));
                write_reg(REG_HIGH, 8'($urandom));
            end
            send_byte(pick_byte());
        end
    endtask

    task automatic test_backpressure();
        set_geometry(8'd0, 8'd0);
        send_gap_pct = 0;
        stall_pct = 0;
        hold_cycles = 400;
        for (int n = 0; n < 40; n++) send_byte(8'($urandom));
    endtask

    // Result monitor and pop driver.
    always @(posedge i_clk) begin
        t_result got;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                got = '{o_col, o_row, o_frame, o_size_log2, o_span_log2, o_pixel_value,
                        o_block_done, o_is_last};
                if (fills_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                    failed = 1'b1;
                end else begin
                    if (got !== fills_due[0]) begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, fills_due[0], got);
                        failed = 1'b1;
                    end
                    void'(fills_due.pop_front());
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial begin
        cfg = '{side_log2: 3'd2, frames_log2: 3'd2, low_value: 8'd0, high_value: 8'd255};
        lvl = 0;
        phase = PH_NODE;
        active = 1'b0;
        cur = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(95, 0, 0);
        test_random(95, 56, 0);
        test_random(95, 0, 56);
        test_random(95, 37, 37);
        test_backpressure();
        wait_idle();
        if (fills_due.size() != 0) failed = 1'b1;
        if (!failed) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #10ms;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
design/bqsd_pkg.sv
design/bqsd_front.sv
design/bqsd_outq.sv
design/bqsd_core.sv
design/binary_quadtree_sequence_decoder.sv
sim/tb_binary_quadtree_sequence_decoder.sv
